[hdl/selective_repeat_arq_controller_core_macros.svh]
// Assertion macros shared by the ARQ controller RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef SELECTIVE_REPEAT_ARQ_CONTROLLER_CORE_MACROS_SVH
`define SELECTIVE_REPEAT_ARQ_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication.
`define SRA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SRA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/sra_pkg.sv]
`timescale 1ns / 1ps

package sra_pkg;

	localparam int SEQ_W  = 4;
	localparam int WINDOW = 8;
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int TMR_W  = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [SEQ_W-1:0] SEQ_MAX  = SEQ_W'(15);
	localparam logic [SEQ_W-1:0] WIN_SEQ  = SEQ_W'(WINDOW);
	localparam logic [SEQ_W-1:0] SEQ_ONE  = SEQ_W'(1);

	localparam logic [TMR_W-1:0] DATA_TIMEOUT_RST = 16'd3000;
	localparam logic [TMR_W-1:0] ACK_TIMEOUT_RST  = 16'd300;

	localparam logic [CFG_IDX_W-1:0] CFG_DATA_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT  = 2'd1;

	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_ACK  = 2'd2;
	localparam logic [1:0] KIND_NAK  = 2'd3;

	typedef enum logic [2:0] {
		CMD_NEW_PKT   = 3'd0,
		CMD_PHY_READY = 3'd1,
		CMD_FRAME     = 3'd2,
		CMD_DATA_TO   = 3'd3,
		CMD_ACK_TO    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_DATA    = 3'd0,
		ACT_NAK     = 3'd1,
		ACT_ACK     = 3'd2,
		ACT_ATIMER  = 3'd3,
		ACT_DELIVER = 3'd4,
		ACT_STOP    = 3'd5,
		ACT_STATUS  = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		TSEL_NONE = 2'd0,
		TSEL_DATA = 2'd1,
		TSEL_ACK  = 2'd2
	} tsel_t;

	typedef struct packed {
		logic [2:0]       cmd;
		logic             frame_ok;
		logic [1:0]       frame_kind;
		logic [SEQ_W-1:0] frame_seq;
		logic [SEQ_W-1:0] frame_ack;
	} item_t;

	typedef struct packed {
		action_t           action;
		logic [SEQ_W-1:0]  seq;
		logic [SEQ_W-1:0]  ack;
		logic [SLOT_W-1:0] slot;
		logic [TMR_W-1:0]  timer_value;
		logic              net_enable;
		logic              last;
	} result_t;

	// One action request from the sequencer to the output stage.
	typedef struct packed {
		logic              valid;
		action_t           action;
		logic [SEQ_W-1:0]  seq;
		logic [SEQ_W-1:0]  ack;
		logic [SLOT_W-1:0] slot;
		tsel_t             tsel;
		logic              net_enable;
		logic              last;
	} act_req_t;

endpackage

[hdl/sra_wincmp.sv]
`timescale 1ns / 1ps

// Circular window test: lo <= val < hi modulo the sequence space.
module sra_wincmp (
	input  logic [sra_pkg::SEQ_W-1:0] lo,
	input  logic [sra_pkg::SEQ_W-1:0] val,
	input  logic [sra_pkg::SEQ_W-1:0] hi,
	output logic                      hit
);

	assign hit = ((lo <= val) && (val < hi)) ||
	             ((hi < lo) && (lo <= val)) ||
	             ((val < hi) && (hi < lo));

endmodule

[hdl/sra_ctrl.sv]
`timescale 1ns / 1ps
`include "selective_repeat_arq_controller_core_macros.svh"

module sra_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sra_pkg::item_t      item,
	output logic                busy,
	output sra_pkg::act_req_t   act
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_EXEC   = 8'b0000_0010,
		S_RX1    = 8'b0000_0100,
		S_RX2    = 8'b0000_1000,
		S_DELIV  = 8'b0001_0000,
		S_NAKRS  = 8'b0010_0000,
		S_STOP   = 8'b0100_0000,
		S_STATUS = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	sra_pkg::item_t item_q;

	logic [sra_pkg::SEQ_W-1:0] oldest_q, oldest_d;
	logic [sra_pkg::SEQ_W-1:0] next_q, next_d;
	logic [sra_pkg::SEQ_W-1:0] expected_q, expected_d;
	logic [sra_pkg::SEQ_W-1:0] limit_q, limit_d;
	logic [sra_pkg::SEQ_W-1:0] outst_q, outst_d;
	logic [sra_pkg::SEQ_W-1:0] guard_q, guard_d;
	logic [sra_pkg::WINDOW-1:0] arrived_q, arrived_d;
	logic nak_ok_q, nak_ok_d;
	logic link_q, link_d;
	logic started_q, started_d;
	logic delivered_q, delivered_d;

	logic [sra_pkg::SEQ_W-1:0] win_lo, win_val, win_hi;
	logic [sra_pkg::SEQ_W-1:0] ack_num;
	logic [sra_pkg::SEQ_W-1:0] nak_resend;
	logic win_hit;

	assign busy       = (state_q != S_IDLE);
	assign ack_num    = expected_q + sra_pkg::SEQ_MAX;
	assign nak_resend = item_q.frame_ack + sra_pkg::SEQ_ONE;

	// operand select for the shared window comparator
	always_comb begin
		case (state_q)
			S_RX2: begin
				win_lo  = expected_q;
				win_val = item_q.frame_seq;
				win_hi  = limit_q;
			end
			S_NAKRS: begin
				win_lo  = oldest_q;
				win_val = nak_resend;
				win_hi  = next_q;
			end
			default: begin
				win_lo  = oldest_q;
				win_val = item_q.frame_ack;
				win_hi  = next_q;
			end
		endcase
	end

	sra_wincmp u_wincmp (
		.lo  (win_lo),
		.val (win_val),
		.hi  (win_hi),
		.hit (win_hit)
	);

	always_comb begin
		state_d     = state_q;
		oldest_d    = oldest_q;
		next_d      = next_q;
		expected_d  = expected_q;
		limit_d     = limit_q;
		outst_d     = outst_q;
		guard_d     = guard_q;
		arrived_d   = arrived_q;
		nak_ok_d    = nak_ok_q;
		link_d      = link_q;
		started_d   = started_q;
		delivered_d = delivered_q;
		act         = '0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				started_d   = 1'b0;
				delivered_d = 1'b0;
				guard_d     = '0;
				state_d     = S_STATUS;
				case (item_q.cmd)
					sra_pkg::CMD_NEW_PKT: begin
						if (outst_q < sra_pkg::WIN_SEQ) begin
							outst_d    = outst_q + sra_pkg::SEQ_ONE;
							next_d     = next_q + sra_pkg::SEQ_ONE;
							link_d     = 1'b0;
							act.valid  = 1'b1;
							act.action = sra_pkg::ACT_DATA;
							act.seq    = next_q;
							act.ack    = ack_num;
							act.slot   = next_q[sra_pkg::SLOT_W-1:0];
							act.tsel   = sra_pkg::TSEL_DATA;
						end
					end
					sra_pkg::CMD_PHY_READY: begin
						link_d = 1'b1;
					end
					sra_pkg::CMD_FRAME: begin
						if (!item_q.frame_ok) begin
							if (nak_ok_q) begin
								nak_ok_d   = 1'b0;
								link_d     = 1'b0;
								act.valid  = 1'b1;
								act.action = sra_pkg::ACT_NAK;
								act.ack    = ack_num;
							end
						end else if (item_q.frame_kind == sra_pkg::KIND_DATA) begin
							state_d = S_RX1;
						end else if (item_q.frame_kind == sra_pkg::KIND_NAK) begin
							state_d = S_NAKRS;
						end else begin
							state_d = S_STOP;
						end
					end
					sra_pkg::CMD_DATA_TO: begin
						link_d     = 1'b0;
						act.valid  = 1'b1;
						act.action = sra_pkg::ACT_DATA;
						act.seq    = oldest_q;
						act.ack    = ack_num;
						act.slot   = oldest_q[sra_pkg::SLOT_W-1:0];
						act.tsel   = sra_pkg::TSEL_DATA;
					end
					sra_pkg::CMD_ACK_TO: begin
						link_d     = 1'b0;
						act.valid  = 1'b1;
						act.action = sra_pkg::ACT_ACK;
						act.ack    = ack_num;
					end
					default: begin
					end
				endcase
			end
			S_RX1: begin
				state_d   = S_RX2;
				act.valid = 1'b1;
				if ((item_q.frame_seq != expected_q) && nak_ok_q) begin
					nak_ok_d   = 1'b0;
					link_d     = 1'b0;
					act.action = sra_pkg::ACT_NAK;
					act.ack    = ack_num;
				end else begin
					started_d  = 1'b1;
					act.action = sra_pkg::ACT_ATIMER;
					act.tsel   = sra_pkg::TSEL_ACK;
				end
			end
			S_RX2: begin
				if (win_hit && !arrived_q[item_q.frame_seq[sra_pkg::SLOT_W-1:0]]) begin
					arrived_d[item_q.frame_seq[sra_pkg::SLOT_W-1:0]] = 1'b1;
					state_d = S_DELIV;
				end else begin
					state_d = S_STOP;
				end
			end
			S_DELIV: begin
				// hand up in-order frames one per cycle
				if (arrived_q[expected_q[sra_pkg::SLOT_W-1:0]]) begin
					arrived_d[expected_q[sra_pkg::SLOT_W-1:0]] = 1'b0;
					nak_ok_d    = 1'b1;
					expected_d  = expected_q + sra_pkg::SEQ_ONE;
					limit_d     = limit_q + sra_pkg::SEQ_ONE;
					delivered_d = 1'b1;
					act.valid   = 1'b1;
					act.action  = sra_pkg::ACT_DELIVER;
					act.seq     = expected_q;
					act.slot    = expected_q[sra_pkg::SLOT_W-1:0];
				end else begin
					state_d = S_STOP;
					if (delivered_q && !started_q) begin
						act.valid  = 1'b1;
						act.action = sra_pkg::ACT_ATIMER;
						act.tsel   = sra_pkg::TSEL_ACK;
					end
				end
			end
			S_NAKRS: begin
				state_d = S_STOP;
				if (win_hit) begin
					link_d     = 1'b0;
					act.valid  = 1'b1;
					act.action = sra_pkg::ACT_DATA;
					act.seq    = nak_resend;
					act.ack    = ack_num;
					act.slot   = nak_resend[sra_pkg::SLOT_W-1:0];
					act.tsel   = sra_pkg::TSEL_DATA;
				end
			end
			S_STOP: begin
				// retire acknowledged frames one per cycle
				if ((guard_q < sra_pkg::WIN_SEQ) && win_hit) begin
					if (outst_q != '0) begin
						outst_d = outst_q - sra_pkg::SEQ_ONE;
					end
					oldest_d   = oldest_q + sra_pkg::SEQ_ONE;
					guard_d    = guard_q + sra_pkg::SEQ_ONE;
					act.valid  = 1'b1;
					act.action = sra_pkg::ACT_STOP;
					act.seq    = oldest_q;
					act.slot   = oldest_q[sra_pkg::SLOT_W-1:0];
				end else begin
					state_d = S_STATUS;
				end
			end
			S_STATUS: begin
				state_d        = S_IDLE;
				act.valid      = 1'b1;
				act.action     = sra_pkg::ACT_STATUS;
				act.net_enable = (outst_q < sra_pkg::WIN_SEQ) && link_q;
				act.last       = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			oldest_q    <= '0;
			next_q      <= '0;
			expected_q  <= '0;
			limit_q     <= sra_pkg::WIN_SEQ;
			outst_q     <= '0;
			guard_q     <= '0;
			arrived_q   <= '0;
			nak_ok_q    <= 1'b1;
			link_q      <= 1'b0;
			started_q   <= 1'b0;
			delivered_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			oldest_q    <= oldest_d;
			next_q      <= next_d;
			expected_q  <= expected_d;
			limit_q     <= limit_d;
			outst_q     <= outst_d;
			guard_q     <= guard_d;
			arrived_q   <= arrived_d;
			nak_ok_q    <= nak_ok_d;
			link_q      <= link_d;
			started_q   <= started_d;
			delivered_q <= delivered_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end
	end

	`SRA_ASSERT_IMP(a_guard_bound, 1'b1, guard_q <= sra_pkg::WIN_SEQ, "stop loop overran")
	`SRA_ASSERT_IMP(a_outst_bound, 1'b1, outst_q <= sra_pkg::WIN_SEQ, "outstanding over window")
	`SRA_ASSERT_IMP(a_idle_quiet, state_q == S_IDLE, !act.valid, "action while idle")
	`SRA_ASSERT_NXT(a_deliver_adv, act.valid && (act.action == sra_pkg::ACT_DELIVER), expected_q == ($past(expected_q) + sra_pkg::SEQ_ONE), "deliver without advance")

endmodule

[hdl/selective_repeat_arq_controller_core.sv]
`timescale 1ns / 1ps
`include "selective_repeat_arq_controller_core_macros.svh"
// The first result of an event comes from the command step through the output register, or
//   from a later step when the command step emits nothing; the status item shows in the same cycle that busy falls.
// A start is taken only while the core is idle, so one event finishes before the next begins;
//   the sequencer emits at most one action per cycle through a single window comparator.
// Results are strobed for one cycle and the receiver cannot stall them.
// Reset (arst_n low, asynchronous) clears window state (receive limit to 8, NAK enabled), timeouts to 3000 and 300.

module selective_repeat_arq_controller_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// event channel
	input  logic                                start,
	output logic                                busy,
	input  sra_pkg::item_t                      item,
	// action channel
	output logic                                result_valid,
	output sra_pkg::result_t                    result,
	// register write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sra_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sra_pkg::TMR_W-1:0]           cfg_data
);

	sra_pkg::act_req_t act;

	logic [sra_pkg::TMR_W-1:0] data_to_q;
	logic [sra_pkg::TMR_W-1:0] ack_to_q;
	logic [sra_pkg::TMR_W-1:0] timer_sel;
	logic                      result_valid_q;
	sra_pkg::result_t          result_q;

	// Registers are to be written only while idle; the block itself does not enforce it, so always take the transfer.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_to_q <= sra_pkg::DATA_TIMEOUT_RST;
			ack_to_q  <= sra_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			// drop writes to unknown indexes
			case (cfg_index)
				sra_pkg::CFG_DATA_TIMEOUT: data_to_q <= cfg_data;
				sra_pkg::CFG_ACK_TIMEOUT:  ack_to_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer: walks one event through its action steps.
	sra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.act    (act)
	);

	// Attach the timer duration that belongs to the action.
	always_comb begin
		case (act.tsel)
			sra_pkg::TSEL_DATA: timer_sel = data_to_q;
			sra_pkg::TSEL_ACK:  timer_sel = ack_to_q;
			default:            timer_sel = '0;
		endcase
	end

	// Output register: hold each action for exactly one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= act.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.action      <= act.action;
		result_q.seq         <= act.seq;
		result_q.ack         <= act.ack;
		result_q.slot        <= act.slot;
		result_q.timer_value <= timer_sel;
		result_q.net_enable  <= act.net_enable;
		result_q.last        <= act.last;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The status item closes the event: the core must be free when it shows.
	`SRA_ASSERT_IMP(a_last_ends, result_valid && result.last, !busy, "status while busy")

endmodule
